/* sv/bcp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the call-context parser.
// No dependencies; every other file of the block imports this package.
package bcp_pkg;

  // Line length limit used by the final report
  localparam int MaxLine = 256;

  // Configuration register indexes
  localparam logic [2:0] RegOpen      = 3'd0;
  localparam logic [2:0] RegSeparator = 3'd1;
  localparam logic [2:0] RegClose     = 3'd2;
  localparam logic [2:0] RegTerm      = 3'd3;
  localparam logic [2:0] RegExtraWord = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] OpenReset  = 8'd40;
  localparam logic [7:0] SepReset   = 8'd44;
  localparam logic [7:0] CloseReset = 8'd41;
  localparam logic [7:0] TermReset  = 8'd59;
  localparam logic [7:0] ExtraReset = 8'd0;

  // Saturation limits
  localparam logic [8:0] ColumnMax = 9'd511;
  localparam logic [7:0] ByteMax   = 8'd255;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic       line_too_long;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] name_column;
    logic [7:0] name_length;
    logic [7:0] param_index;
    logic       overflow;
  } out_item_t;

  // One nesting context: call valid, identifier column, length, parameter count
  typedef struct packed {
    logic       valid;
    logic [7:0] col;
    logic [7:0] len;
    logic [7:0] param;
  } ctx_t;

  typedef struct packed {
    logic [7:0] open_char;
    logic [7:0] separator_char;
    logic [7:0] close_char;
    logic [7:0] terminator_char;
    logic [7:0] extra_word_char;
  } cfg_t;

  // Character class flags handed from the lexer to the sequencer
  typedef struct packed {
    logic word;
    logic space;
    logic open;
    logic sep;
    logic close;
    logic term;
  } char_class_t;

endpackage

/* sv/bracket_call_context_parser_core.sv */
`timescale 1ns / 1ps
// Call-context parser: takes the characters of a line up to the cursor, one
// item each, tracks bracket nesting on a context stack, and on the item marked
// last reports the innermost enclosing call (column, length, parameter index).
// Channels: char_* carries input items, res_* carries result items (one per
// item with last set), cfg_* writes the five character registers (always
// ready; write only while the block is idle).
// Sequencing: an ordinary character is taken in StIdle; a close character that
// pops the stack also passes through StPop, since the popped context comes out
// of the stack memory as registered read data. An item marked last then unwinds
// the stack to the innermost call, via StWait for each non-call level passed,
// and loads the result in StUnw. char_ready is low during pops and unwinds.
// The result register holds its item until res_ready; a new item may be taken
// meanwhile, and a later unwind waits for the register to drain.
// Reset clears the nesting state and loads the register defaults. The stack
// memory needs no clearing pass: only entries pushed since the line start are
// ever read.
// Depends on bcp_pkg, bcp_lexer and bcp_stack.
module bracket_call_context_parser_core #(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  bcp_pkg::in_item_t char_item,
  output logic              res_valid,
  input  logic              res_ready,
  output bcp_pkg::out_item_t res_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import bcp_pkg::*;

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPop  = 2'd1;
  localparam logic [1:0] StUnw  = 2'd2;
  localparam logic [1:0] StWait = 2'd3;

  logic [1:0]     state;
  logic [1:0]     state_next;
  cfg_t           cfg;
  ctx_t           cur;
  ctx_t           cur_next;
  logic [SpW-1:0] sp;
  logic [SpW-1:0] sp_next;
  logic           prev_id;
  logic           prev_id_next;
  logic           in_word;
  logic           in_word_next;
  logic [7:0]     word_start;
  logic [7:0]     word_start_next;
  logic [7:0]     word_length;
  logic [7:0]     word_length_next;
  logic [8:0]     column_count;
  logic [8:0]     column_next;
  logic           overflow_flag;
  logic           overflow_next;
  logic           pend_last;
  logic           too_long;
  ctx_t           u_ctx;
  logic [SpW-1:0] u_sp;

  // Values seen by the item after an optional line-start clear
  ctx_t           b_cur;
  logic [SpW-1:0] b_sp;
  logic [SpW-1:0] b_sp_dec;
  logic           b_prev_id;
  logic           b_in_word;
  logic [7:0]     b_ws;
  logic [7:0]     b_wl;
  logic [8:0]     b_col;
  logic           b_ovf;

  char_class_t    cls;
  logic           accept;
  logic           do_pop;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  logic [SpW-1:0] u_sp_dec;
  ctx_t           mem_rdata;
  logic           found;
  logic           res_load;

  bcp_lexer u_lexer (
    .ch  (char_item.ch),
    .cfg (cfg),
    .cls (cls)
  );

  bcp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (b_cur),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign char_ready = (state == StIdle);
  assign cfg_ready  = 1'b1;
  assign accept     = char_valid && char_ready;

  // Clear state at line start
  always_comb begin
    if (char_item.first) begin
      b_cur     = '0;
      b_sp      = '0;
      b_prev_id = 1'b0;
      b_in_word = 1'b0;
      b_ws      = '0;
      b_wl      = '0;
      b_col     = '0;
      b_ovf     = 1'b0;
    end else begin
      b_cur     = cur;
      b_sp      = sp;
      b_prev_id = prev_id;
      b_in_word = in_word;
      b_ws      = word_start;
      b_wl      = word_length;
      b_col     = column_count;
      b_ovf     = overflow_flag;
    end
  end

  assign b_sp_dec = b_sp - 1'b1;
  assign u_sp_dec = u_sp - 1'b1;

  // Take one character: tokenize and update the nesting context
  always_comb begin
    cur_next         = b_cur;
    sp_next          = b_sp;
    prev_id_next     = b_prev_id;
    in_word_next     = b_in_word;
    word_start_next  = b_ws;
    word_length_next = b_wl;
    overflow_next    = b_ovf;
    do_pop           = 1'b0;
    mem_we           = 1'b0;
    column_next      = (b_col < ColumnMax) ? b_col + 9'd1 : b_col;

    if (cls.word) begin
      if (!b_in_word) begin
        word_start_next  = b_col[8] ? ByteMax : b_col[7:0];
        word_length_next = 8'd1;
      end else if (b_wl < ByteMax) begin
        word_length_next = b_wl + 8'd1;
      end
      in_word_next = 1'b1;
      prev_id_next = 1'b1;
    end else begin
      in_word_next = 1'b0;
      if (!cls.space) begin
        prev_id_next = 1'b0;
        priority if (cls.open) begin
          if (b_sp < SpW'(STACK_DEPTH)) begin
            mem_we  = accept;
            sp_next = b_sp + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
          cur_next.param = '0;
          if (b_prev_id) begin
            cur_next.valid = 1'b1;
            cur_next.col   = b_ws;
            cur_next.len   = b_wl;
          end else begin
            cur_next.valid = 1'b0;
            cur_next.col   = '0;
            cur_next.len   = '0;
          end
        end else if (cls.sep && b_cur.valid) begin
          if (b_cur.param < ByteMax) begin
            cur_next.param = b_cur.param + 8'd1;
          end
        end else if (cls.close) begin
          if (b_sp != '0) begin
            sp_next = b_sp_dec;
            do_pop  = 1'b1;
          end else begin
            cur_next = '0;
          end
        end else if (cls.term) begin
          sp_next  = '0;
          cur_next = '0;
        end else begin
          cur_next = b_cur;
        end
      end
    end
  end

  assign mem_waddr = b_sp[AW-1:0];
  assign mem_raddr = (state == StIdle) ? b_sp_dec[AW-1:0] : u_sp_dec[AW-1:0];

  // Report test for the innermost call
  assign found = u_ctx.valid && !overflow_flag && !too_long &&
                 (column_count >= 9'd2) && (32'(column_count) + 32'd3 < MaxLine);
  assign res_load = (state == StUnw) && (u_ctx.valid || (u_sp == '0)) &&
                    (!res_valid || res_ready);

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: begin
        if (accept) begin
          if (do_pop) begin
            state_next = StPop;
          end else if (char_item.last) begin
            state_next = StUnw;
          end
        end
      end
      StPop: begin
        state_next = pend_last ? StUnw : StIdle;
      end
      StUnw: begin
        if (u_ctx.valid || (u_sp == '0)) begin
          if (!res_valid || res_ready) begin
            state_next = StIdle;
          end
        end else begin
          state_next = StWait;
        end
      end
      StWait: begin
        state_next = StUnw;
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // Control and context state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      cur           <= '0;
      sp            <= '0;
      prev_id       <= 1'b0;
      in_word       <= 1'b0;
      word_start    <= '0;
      word_length   <= '0;
      column_count  <= '0;
      overflow_flag <= 1'b0;
      pend_last     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cur           <= cur_next;
        sp            <= sp_next;
        prev_id       <= prev_id_next;
        in_word       <= in_word_next;
        word_start    <= word_start_next;
        word_length   <= word_length_next;
        column_count  <= column_next;
        overflow_flag <= overflow_next;
        pend_last     <= char_item.last;
      end
      // Load the popped context
      if (state == StPop) begin
        cur <= mem_rdata;
      end
      // Hold the result until taken; a new load replaces a taken item
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Unwind working copy and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      too_long <= char_item.line_too_long;
      u_ctx    <= cur_next;
      u_sp     <= sp_next;
    end
    if (state == StPop) begin
      u_ctx <= mem_rdata;
    end
    if ((state == StUnw) && !u_ctx.valid && (u_sp != '0)) begin
      u_sp <= u_sp_dec;
    end
    if (state == StWait) begin
      u_ctx <= mem_rdata;
    end
    if (res_load) begin
      res_item.found       <= found;
      res_item.name_column <= found ? u_ctx.col : 8'd0;
      res_item.name_length <= found ? u_ctx.len : 8'd0;
      res_item.param_index <= found ? u_ctx.param : 8'd0;
      res_item.overflow    <= overflow_flag;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_char       <= OpenReset;
      cfg.separator_char  <= SepReset;
      cfg.close_char      <= CloseReset;
      cfg.terminator_char <= TermReset;
      cfg.extra_word_char <= ExtraReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegOpen:      cfg.open_char       <= cfg_data;
        RegSeparator: cfg.separator_char  <= cfg_data;
        RegClose:     cfg.close_char      <= cfg_data;
        RegTerm:      cfg.terminator_char <= cfg_data;
        RegExtraWord: cfg.extra_word_char <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/bcp_lexer.sv */
`timescale 1ns / 1ps
// Character classifier: word, whitespace and the configured punctuation codes.
// Depends on bcp_pkg.
module bcp_lexer (
  input  logic [7:0]          ch,
  input  bcp_pkg::cfg_t       cfg,
  output bcp_pkg::char_class_t cls
);
  import bcp_pkg::*;

  logic is_alpha;
  logic is_digit;

  // Identifier characters
  assign is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit = (ch >= 8'h30 && ch <= 8'h39);

  always_comb begin
    cls.word  = is_alpha || is_digit || (ch == 8'h5F) ||
                ((cfg.extra_word_char != 8'd0) && (ch == cfg.extra_word_char));
    cls.space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) || (ch == 8'h0D);
    cls.open  = (ch == cfg.open_char);
    cls.sep   = (ch == cfg.separator_char);
    cls.close = (ch == cfg.close_char);
    cls.term  = (ch == cfg.terminator_char);
  end

endmodule

/* sv/bcp_stack.sv */
`timescale 1ns / 1ps
// Context stack memory: one write port, one read port with registered data.
// Depends on bcp_pkg.
module bcp_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  bcp_pkg::ctx_t                  wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output bcp_pkg::ctx_t                  rdata
);
  import bcp_pkg::*;

  ctx_t mem [STACK_DEPTH];

  // Write pushed contexts; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for bracket_call_context_parser_core: a directed table, then random lines,
// checked item by item against a behavioral copy of the parser. Depends on bcp_pkg.
module tb_top;
  import bcp_pkg::*;

  localparam int StackDepth   = 256;
  localparam int CycleLimit   = 400000;
  localparam int UnwindSettle = 600;
  localparam int HoldCycles   = 400;

  // Whitespace characters skipped by the tokenizer
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Indexes with no register behind them
  localparam logic [2:0] RegSpareA = 3'd5;
  localparam logic [2:0] RegSpareB = 3'd6;
  localparam logic [2:0] RegSpareC = 3'd7;

  localparam out_item_t NoCall = '0;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // Directed rows under the reset character set; typed rows carry their result
  localparam dir_row_t DirRows [25] = '{
    '{'{"x", 1'b1, 1'b1, 1'b0}, 1'b1, NoCall},
    '{'{"f", 1'b1, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"(", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"a", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{",", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"b", 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b1, 8'd0, 8'd1, 8'd1, 1'b0}},
    '{'{" ", 1'b0, 1'b1, 1'b1}, 1'b1, NoCall},
    '{'{")", 1'b0, 1'b1, 1'b0}, 1'b1, NoCall},
    '{'{")", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"g", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"o", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"(", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"(", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{",", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"z", 1'b0, 1'b1, 1'b0}, 1'b0, NoCall},
    '{'{";", 1'b0, 1'b1, 1'b0}, 1'b1, NoCall},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b1, NoCall},
    '{'{"_", 1'b1, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"9", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"(", 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{8'h0A, 1'b0, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{",", 1'b0, 1'b1, 1'b0}, 1'b0, NoCall},
    '{'{" ", 1'b1, 1'b0, 1'b0}, 1'b0, NoCall},
    '{'{"(", 1'b0, 1'b1, 1'b0}, 1'b1, NoCall}
  };

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_ready;
  in_item_t  char_item  = '0;
  logic      res_valid;
  logic      res_ready  = 1'b0;
  out_item_t res_item;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  // Behavioral copy of the parser state and character set
  cfg_t       char_cfg;
  ctx_t       nest_stack [StackDepth];
  logic [8:0] nest_sp;
  ctx_t       cur_ctx;
  bit         after_ident;
  bit         in_ident;
  logic [7:0] ident_start;
  logic [7:0] ident_len;
  logic [8:0] col_count;
  bit         nest_overflow;

  out_item_t  call_tips_q [$];
  in_item_t   line_chars [$];
  int         items_sent   = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  bit         hold_req     = 1'b0;
  bit         hold_done    = 1'b0;
  int         hold_left    = 0;

  bracket_call_context_parser_core #(
    .STACK_DEPTH(StackDepth)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive result ready, hold it off once for a long stretch, and check results
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (call_tips_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result found=%0d col=%0d len=%0d param=%0d overflow=%0d",
                 $time, res_item.found, res_item.name_column, res_item.name_length,
                 res_item.param_index, res_item.overflow);
      end else if (res_item !== call_tips_q[0]) begin
        mismatches++;
        $display("%0t: result mismatch: expected found=%0d col=%0d len=%0d param=%0d ovf=%0d",
                 $time, call_tips_q[0].found, call_tips_q[0].name_column,
                 call_tips_q[0].name_length, call_tips_q[0].param_index,
                 call_tips_q[0].overflow);
        $display("%0t:   actual found=%0d col=%0d len=%0d param=%0d ovf=%0d",
                 $time, res_item.found, res_item.name_column, res_item.name_length,
                 res_item.param_index, res_item.overflow);
        void'(call_tips_q.pop_front());
      end else begin
        void'(call_tips_q.pop_front());
      end
    end
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Clear everything a line start clears
  task automatic clear_line_state();
    nest_sp       = '0;
    cur_ctx       = '0;
    after_ident   = 1'b0;
    in_ident      = 1'b0;
    ident_start   = '0;
    ident_len     = '0;
    col_count     = '0;
    nest_overflow = 1'b0;
  endtask

  function automatic bit is_ident_char(logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_")
      return 1'b1;
    return char_cfg.extra_word_char != 8'd0 && c == char_cfg.extra_word_char;
  endfunction

  // Take one character into the tokenizer and the nesting stack
  task automatic scan_char(logic [7:0] c);
    logic [8:0] col;
    col = col_count;
    if (col_count < ColumnMax) col_count++;
    if (is_ident_char(c)) begin
      if (!in_ident) begin
        ident_start = (col > 9'd255) ? ByteMax : col[7:0];
        ident_len   = 8'd1;
      end else if (ident_len < ByteMax) begin
        ident_len++;
      end
      in_ident    = 1'b1;
      after_ident = 1'b1;
    end else begin
      in_ident = 1'b0;
      if (!(c == ChSpace || c == ChTab || c == ChLf || c == ChCr)) begin
        // Open, then separator inside a call, then close, then terminator
        if (c == char_cfg.open_char) begin
          if (nest_sp < StackDepth) begin
            nest_stack[nest_sp] = cur_ctx;
            nest_sp++;
          end else begin
            nest_overflow = 1'b1;
          end
          cur_ctx.param = '0;
          if (after_ident) begin
            cur_ctx.valid = 1'b1;
            cur_ctx.col   = ident_start;
            cur_ctx.len   = ident_len;
          end else begin
            cur_ctx.valid = 1'b0;
            cur_ctx.col   = '0;
            cur_ctx.len   = '0;
          end
        end else if (c == char_cfg.separator_char && cur_ctx.valid) begin
          if (cur_ctx.param < ByteMax) cur_ctx.param++;
        end else if (c == char_cfg.close_char) begin
          if (nest_sp > 0) begin
            nest_sp--;
            cur_ctx = nest_stack[nest_sp];
          end else begin
            cur_ctx = '0;
          end
        end else if (c == char_cfg.terminator_char) begin
          nest_sp = '0;
          cur_ctx = '0;
        end
        after_ident = 1'b0;
      end
    end
  endtask

  // Advance the model by one item; on a last item unwind to the innermost call
  task automatic predict_cursor(input in_item_t it, output bit has_tip, output out_item_t tip);
    ctx_t c;
    int   p;
    bit   hit;
    if (it.first) clear_line_state();
    scan_char(it.ch);
    has_tip = it.last;
    tip     = '0;
    if (it.last) begin
      c = cur_ctx;
      p = nest_sp;
      while (!c.valid && p > 0) begin
        p--;
        c = nest_stack[p];
      end
      hit = c.valid && !nest_overflow && !it.line_too_long && col_count >= 9'd2 &&
            int'(col_count) + 3 < MaxLine;
      tip.found = hit;
      if (hit) begin
        tip.name_column = c.col;
        tip.name_length = c.len;
        tip.param_index = c.param;
      end
      tip.overflow = nest_overflow;
    end
  endtask

  // Offer one item with random idle cycles ahead; predict once it is taken
  task automatic send_char(input in_item_t it, input logic typed, input out_item_t want);
    bit        has;
    out_item_t tip;
    while ($urandom_range(99) < snd_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    predict_cursor(it, has, tip);
    if (has) call_tips_q.insert(call_tips_q.size(), typed ? want : tip);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i], 1'b0, NoCall);
  endtask

  task automatic push_char(logic [7:0] c, int last_pct, int ltl_pct);
    in_item_t it;
    it.ch            = c;
    it.first         = (line_chars.size() == 0);
    it.last          = ($urandom_range(99) < last_pct);
    it.line_too_long = ($urandom_range(99) < ltl_pct);
    line_chars.insert(line_chars.size(), it);
  endtask

  function automatic logic [7:0] pick_ident_char();
    int r;
    r = $urandom_range(63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62 || char_cfg.extra_word_char == 8'd0) return "_";
    return char_cfg.extra_word_char;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      default: return ChCr;
    endcase
  endfunction

  // Build a token-shaped line: identifiers often followed by an open character
  task automatic build_line(int target);
    int r;
    int n;
    line_chars.delete();
    while (line_chars.size() < target) begin
      r = $urandom_range(99);
      if (r < 30) begin
        n = $urandom_range(1, 5);
        repeat (n) push_char(pick_ident_char(), 10, 8);
        if ($urandom_range(99) < 60) push_char(char_cfg.open_char, 10, 8);
      end else if (r < 45) begin
        push_char(char_cfg.open_char, 10, 8);
      end else if (r < 60) begin
        push_char(char_cfg.separator_char, 10, 8);
      end else if (r < 72) begin
        push_char(char_cfg.close_char, 10, 8);
      end else if (r < 80) begin
        push_char(pick_blank(), 10, 8);
      end else if (r < 83) begin
        push_char(char_cfg.terminator_char, 10, 8);
      end else begin
        push_char(8'($urandom_range(255)), 10, 8);
      end
    end
    line_chars[line_chars.size() - 1].last = 1'b1;
  endtask

  // Build raw bytes with random line starts and cursor marks
  task automatic build_noise(int target);
    line_chars.delete();
    repeat (target) push_char(8'($urandom_range(255)), 20, 50);
    foreach (line_chars[i]) line_chars[i].first = ($urandom_range(99) < 10);
  endtask

  // Build one call whose line crosses the length limit, cursor marks around it
  task automatic build_long_call();
    line_chars.delete();
    push_char("f", 0, 0);
    push_char("n", 0, 0);
    push_char(char_cfg.open_char, 0, 0);
    while (line_chars.size() < 260) begin
      case ($urandom_range(3))
        0: push_char(char_cfg.separator_char, (line_chars.size() >= 247) ? 100 : 3, 0);
        1: push_char(pick_blank(), (line_chars.size() >= 247) ? 100 : 3, 0);
        default: push_char(pick_ident_char(), (line_chars.size() >= 247) ? 100 : 3, 0);
      endcase
    end
    line_chars[line_chars.size() - 1].last = 1'b1;
  endtask

  // Build nesting that fills the stack and then goes one level deeper
  task automatic build_deep_nest();
    line_chars.delete();
    push_char("g", 0, 0);
    for (int i = 1; i <= StackDepth + 1; i++)
      push_char(char_cfg.open_char, (i >= StackDepth) ? 100 : 0, 0);
    repeat (6) push_char(char_cfg.close_char, 0, 0);
    push_char(pick_ident_char(), 0, 0);
    push_char(char_cfg.separator_char, 100, 0);
  endtask

  task automatic run_random(int quota);
    int stop;
    int r;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 5) build_noise($urandom_range(1, 12));
      else if (r < 10) build_line(1);
      else build_line($urandom_range(2, 20));
      send_line();
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    char_valid <= 1'b0;
    while (call_tips_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      RegOpen:      char_cfg.open_char       = val;
      RegSeparator: char_cfg.separator_char  = val;
      RegClose:     char_cfg.close_char      = val;
      RegTerm:      char_cfg.terminator_char = val;
      RegExtraWord: char_cfg.extra_word_char = val;
      default: ;
    endcase
  endtask

  initial begin
    char_cfg = '{OpenReset, SepReset, CloseReset, TermReset, ExtraReset};
    clear_line_state();
    snd_idle_pct = 29;
    rcv_idle_pct = 54;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset character set: directed table, random lines, length limit
    foreach (DirRows[i]) send_char(DirRows[i].item, DirRows[i].typed, DirRows[i].want);
    run_random(100);
    build_long_call();
    send_line();
    settle();

    // Extreme codes, spare indexes ignored
    write_reg(RegOpen, 8'hFF);
    write_reg(RegSeparator, 8'h00);
    write_reg(RegClose, 8'h80);
    write_reg(RegTerm, 8'h01);
    write_reg(RegExtraWord, ".");
    write_reg(RegSpareA, 8'hFF);
    write_reg(RegSpareB, 8'h00);
    snd_idle_pct = 54;
    rcv_idle_pct = 29;
    run_random(120);
    settle();

    // Shared characters: separator doubles as close, open as terminator
    write_reg(RegOpen, "{");
    write_reg(RegSeparator, ",");
    write_reg(RegClose, ",");
    write_reg(RegTerm, "{");
    write_reg(RegExtraWord, 8'hFF);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req     = 1'b1;
    run_random(100);
    settle();

    // Reset codes with an extra word character; overflow the stack
    write_reg(RegOpen, OpenReset);
    write_reg(RegSeparator, SepReset);
    write_reg(RegClose, CloseReset);
    write_reg(RegTerm, TermReset);
    write_reg(RegExtraWord, "$");
    write_reg(RegSpareC, 8'h5A);
    build_deep_nest();
    send_line();
    run_random(40);
    settle();
    repeat (UnwindSettle) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
